// ----- rtl/hhds_pkg.sv -----
// Shared types, field layout and constants for the heading hold drive step block.
// Used by hhds_sense and heading_hold_drive_step_top; depends on nothing.
`default_nettype none

package hhds_pkg;

   localparam int SENSOR_BITS = 12;
   localparam int NUM_SENSORS = 4;

   localparam int TARGET_W  = 16;
   localparam int HEADING_W = 13;
   localparam int DELTA_W   = 10;
   localparam int SCALE_W   = 16;
   localparam int BASE_W    = 9;
   localparam int GAIN_W    = 8;
   localparam int LIMIT_W   = 12;
   localparam int WIN_W     = 24;
   localparam int SPEED_W   = 10;
   localparam int STATUS_W  = 3;
   localparam int REMAIN_W  = 17;
   localparam int SUM_W     = 32;
   localparam int FRAC_W    = 8;

   localparam int REG_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // request word layout, lowest bit up
   localparam int TARGET_LSB  = 0;
   localparam int HEADING_LSB = TARGET_LSB + TARGET_W;
   localparam int DELTA_LSB   = HEADING_LSB + HEADING_W;
   localparam int BUMP_L_LSB  = DELTA_LSB + DELTA_W;
   localparam int BUMP_R_LSB  = BUMP_L_LSB + 1;
   localparam int CLIFF_LSB   = BUMP_R_LSB + 1;
   localparam int REQ_USED_W  = CLIFF_LSB + NUM_SENSORS * SENSOR_BITS;
   localparam int REQ_DATA_W  = ((REQ_USED_W + 7) / 8) * 8;

   // response word layout, lowest bit up
   localparam int LEFT_LSB    = 0;
   localparam int RIGHT_LSB   = LEFT_LSB + SPEED_W;
   localparam int STATUS_LSB  = RIGHT_LSB + SPEED_W;
   localparam int REMAIN_LSB  = STATUS_LSB + STATUS_W;
   localparam int RSP_USED_W  = REMAIN_LSB + REMAIN_W;
   localparam int RSP_DATA_W  = ((RSP_USED_W + 7) / 8) * 8;

   localparam int HALF_TURN  = 2880;
   localparam int FULL_TURN  = 5760;
   localparam int SPEED_MAX  = 500;
   localparam int REMAIN_MIN = -32768;
   localparam int REMAIN_MAX = 65535;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
   localparam logic [BASE_W-1:0]  BASE_RESET  = 9'd50;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 8'd16;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd10;
   localparam logic [NUM_SENSORS-1:0][WIN_W-1:0] TAPE_RESET = {
      24'd3891900, 24'd11266500, 24'd11881000, 24'd14952800
   };

   typedef enum logic [STATUS_W-1:0] {
      ST_IDLE    = 3'd0,
      ST_RUN     = 3'd1,
      ST_REACHED = 3'd2,
      ST_BUMP    = 3'd3,
      ST_TAPE    = 3'd4,
      ST_CLIFF   = 3'd5
   } status_type;

   typedef enum logic {
      CMD_START  = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_DISTANCE_SCALE = 3'd0,
      REG_BASE_SPEED     = 3'd1,
      REG_GAIN           = 3'd2,
      REG_CLIFF_LIMIT    = 3'd3,
      REG_TAPE_LEFT      = 3'd4,
      REG_TAPE_FL        = 3'd5,
      REG_TAPE_FR        = 3'd6,
      REG_TAPE_RIGHT     = 3'd7
   } reg_type;

   typedef struct packed {
      logic bump;
      logic tape;
      logic cliff;
   } stop_type;

endpackage

`default_nettype wire

// ----- rtl/hhds_sense.sv -----
// Stop condition decode: bumpers, per-sensor tape windows and cliff limit.
// Depends on hhds_pkg.
`default_nettype none

module hhds_sense (
   input  wire logic                                                  bump_left,
   input  wire logic                                                  bump_right,
   input  wire logic [hhds_pkg::NUM_SENSORS-1:0][hhds_pkg::SENSOR_BITS-1:0] cliff_sig,
   input  wire logic [hhds_pkg::NUM_SENSORS-1:0][hhds_pkg::WIN_W-1:0]  tape_win,
   input  wire logic [hhds_pkg::LIMIT_W-1:0]                          cliff_limit,
   output hhds_pkg::stop_type                                         stop
);

   localparam int CMP_W = (hhds_pkg::SENSOR_BITS > hhds_pkg::LIMIT_W) ?
                          hhds_pkg::SENSOR_BITS : hhds_pkg::LIMIT_W;

   logic [hhds_pkg::NUM_SENSORS-1:0] tape_hit;
   logic [hhds_pkg::NUM_SENSORS-1:0] cliff_hit;

   always_comb begin
      logic [hhds_pkg::WIN_W-1:0]       win_shift;
      logic [hhds_pkg::SENSOR_BITS-1:0] win_lo;
      logic [hhds_pkg::SENSOR_BITS-1:0] win_hi;
      logic [CMP_W-1:0]                 sig_ext;
      logic [CMP_W-1:0]                 limit_ext;
      limit_ext = CMP_W'(cliff_limit);
      for (int i = 0; i < hhds_pkg::NUM_SENSORS; i++) begin
         win_shift    = tape_win[i] >> hhds_pkg::SENSOR_BITS;
         win_lo       = tape_win[i][hhds_pkg::SENSOR_BITS-1:0];
         win_hi       = win_shift[hhds_pkg::SENSOR_BITS-1:0];
         tape_hit[i]  = (cliff_sig[i] > win_lo) && (cliff_sig[i] < win_hi);
         sig_ext      = CMP_W'(cliff_sig[i]);
         cliff_hit[i] = (sig_ext != '0) && (sig_ext < limit_ext);
      end
   end

   assign stop.bump  = bump_left | bump_right;
   assign stop.tape  = |tape_hit;
   assign stop.cliff = |cliff_hit;

endmodule

`default_nettype wire

// ----- rtl/heading_hold_drive_step_top.sv -----
// Top level of the heading hold drive step: config registers, input stage,
// move state update and response register. Depends on hhds_pkg and hhds_sense.
`default_nettype none

// One request word can be accepted in every clock cycle, and each yields one
// response word. The request is held in the input register, and its response
// in the response register. The input stage registers the odometry product and
// the stop decode. The second stage wraps the heading error, scales it, updates
// the travelled sum and move state, and loads the response register. That
// state update sets the rate: one word per cycle unless the stage is held.
// A waiting response holds the second stage. The input register then takes one
// more word, and the input stalls until the response is taken.

module heading_hold_drive_step_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // tdata: target_mm, heading, distance_delta, bump_left, bump_right,
   //        cliff_left, cliff_front_left, cliff_front_right, cliff_right
   input  wire logic [hhds_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: cmd
   input  wire logic                              req_tuser,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata: left_wheel, right_wheel, move_status, remaining_mm
   output      logic [hhds_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                              csr_wr_en,
   input  wire logic [hhds_pkg::REG_IDX_W-1:0]    csr_index,
   input  wire logic [hhds_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int ODO_W    = hhds_pkg::DELTA_W + hhds_pkg::SCALE_W + 1;
   localparam int ERR_W    = hhds_pkg::HEADING_W + 2;
   localparam int PROD_W   = ERR_W + hhds_pkg::GAIN_W + 1;
   localparam int WHEEL_W  = PROD_W + 1;
   localparam int WIDE_W   = hhds_pkg::SUM_W + 2;

   function automatic logic signed [hhds_pkg::SPEED_W-1:0] wheel_sat(
      input logic signed [WHEEL_W-1:0] v
   );
      logic signed [WHEEL_W-1:0] q;
      q = ((v < 0) ? (v + WHEEL_W'(255)) : v) >>> hhds_pkg::FRAC_W;
      if (q > WHEEL_W'(hhds_pkg::SPEED_MAX)) begin
         q = WHEEL_W'(hhds_pkg::SPEED_MAX);
      end else if (q < -WHEEL_W'(hhds_pkg::SPEED_MAX)) begin
         q = -WHEEL_W'(hhds_pkg::SPEED_MAX);
      end
      return q[hhds_pkg::SPEED_W-1:0];
   endfunction

   // configuration
   logic [hhds_pkg::SCALE_W-1:0]                             scale_ff;
   logic [hhds_pkg::BASE_W-1:0]                              base_ff;
   logic [hhds_pkg::GAIN_W-1:0]                              gain_ff;
   logic [hhds_pkg::LIMIT_W-1:0]                             limit_ff;
   logic [hhds_pkg::NUM_SENSORS-1:0][hhds_pkg::WIN_W-1:0]    tape_win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= hhds_pkg::SCALE_RESET;
         base_ff     <= hhds_pkg::BASE_RESET;
         gain_ff     <= hhds_pkg::GAIN_RESET;
         limit_ff    <= hhds_pkg::LIMIT_RESET;
         tape_win_ff <= hhds_pkg::TAPE_RESET;
      end else if (csr_wr_en) begin
         unique case (hhds_pkg::reg_type'(csr_index))
            hhds_pkg::REG_DISTANCE_SCALE: scale_ff <= csr_wdata[hhds_pkg::SCALE_W-1:0];
            hhds_pkg::REG_BASE_SPEED:     base_ff  <= csr_wdata[hhds_pkg::BASE_W-1:0];
            hhds_pkg::REG_GAIN:           gain_ff  <= csr_wdata[hhds_pkg::GAIN_W-1:0];
            hhds_pkg::REG_CLIFF_LIMIT:    limit_ff <= csr_wdata[hhds_pkg::LIMIT_W-1:0];
            hhds_pkg::REG_TAPE_LEFT:  tape_win_ff[0] <= csr_wdata[hhds_pkg::WIN_W-1:0];
            hhds_pkg::REG_TAPE_FL:    tape_win_ff[1] <= csr_wdata[hhds_pkg::WIN_W-1:0];
            hhds_pkg::REG_TAPE_FR:    tape_win_ff[2] <= csr_wdata[hhds_pkg::WIN_W-1:0];
            hhds_pkg::REG_TAPE_RIGHT: tape_win_ff[3] <= csr_wdata[hhds_pkg::WIN_W-1:0];
            default: ;
         endcase
      end
   end

   // input stage
   logic [hhds_pkg::NUM_SENSORS-1:0][hhds_pkg::SENSOR_BITS-1:0] cliff_sig;
   logic signed [hhds_pkg::DELTA_W-1:0]  req_delta;
   logic signed [ODO_W-1:0]              odo_in;
   hhds_pkg::stop_type                   stop_in;

   assign cliff_sig = req_tdata[hhds_pkg::CLIFF_LSB +:
                                hhds_pkg::NUM_SENSORS * hhds_pkg::SENSOR_BITS];
   assign req_delta = $signed(req_tdata[hhds_pkg::DELTA_LSB +: hhds_pkg::DELTA_W]);
   assign odo_in    = req_delta * $signed({1'b0, scale_ff});

   hhds_sense u_sense (
      .bump_left   (req_tdata[hhds_pkg::BUMP_L_LSB]),
      .bump_right  (req_tdata[hhds_pkg::BUMP_R_LSB]),
      .cliff_sig   (cliff_sig),
      .tape_win    (tape_win_ff),
      .cliff_limit (limit_ff),
      .stop        (stop_in)
   );

   logic                                 s1_valid_ff;
   hhds_pkg::cmd_type                    s1_cmd_ff;
   logic [hhds_pkg::TARGET_W-1:0]        s1_target_ff;
   logic [hhds_pkg::HEADING_W-1:0]       s1_heading_ff;
   logic signed [ODO_W-1:0]              s1_odo_ff;
   hhds_pkg::stop_type                   s1_stop_ff;

   logic advance;
   logic req_take;

   assign advance    = s1_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff     <= hhds_pkg::cmd_type'(req_tuser);
         s1_target_ff  <= req_tdata[hhds_pkg::TARGET_LSB +: hhds_pkg::TARGET_W];
         s1_heading_ff <= req_tdata[hhds_pkg::HEADING_LSB +: hhds_pkg::HEADING_W];
         s1_odo_ff     <= odo_in;
         s1_stop_ff    <= stop_in;
      end
   end

   // move state
   logic                                 active_ff, active_in;
   logic [hhds_pkg::HEADING_W-1:0]       ref_ff, ref_in;
   logic [hhds_pkg::TARGET_W-1:0]        target_ff, target_in;
   logic signed [hhds_pkg::SUM_W-1:0]    sum_ff, sum_in;

   // heading correction
   logic signed [ERR_W-1:0]   err_raw;
   logic signed [ERR_W-1:0]   err_wrap;
   logic signed [PROD_W-1:0]  prod;
   logic signed [WHEEL_W-1:0] base_scaled;
   logic signed [hhds_pkg::SPEED_W-1:0] left_calc, right_calc;

   assign err_raw = $signed({2'b00, ref_ff}) - $signed({2'b00, s1_heading_ff});

   always_comb begin
      if (err_raw > ERR_W'(hhds_pkg::HALF_TURN)) begin
         err_wrap = err_raw - ERR_W'(hhds_pkg::FULL_TURN);
      end else if (err_raw < -ERR_W'(hhds_pkg::HALF_TURN)) begin
         err_wrap = err_raw + ERR_W'(hhds_pkg::FULL_TURN);
      end else begin
         err_wrap = err_raw;
      end
   end

   assign prod        = err_wrap * $signed({1'b0, gain_ff});
   assign base_scaled = $signed(WHEEL_W'({base_ff, {hhds_pkg::FRAC_W{1'b0}}}));
   assign left_calc   = wheel_sat(base_scaled - WHEEL_W'(prod));
   assign right_calc  = wheel_sat(base_scaled + WHEEL_W'(prod));

   // odometry sum with saturation
   logic signed [hhds_pkg::SUM_W:0]   sum_wide;
   logic signed [hhds_pkg::SUM_W-1:0] sum_sat;
   logic signed [hhds_pkg::SUM_W:0]   target_scaled;
   logic                              reached;

   assign sum_wide = (hhds_pkg::SUM_W + 1)'(sum_ff) + (hhds_pkg::SUM_W + 1)'(s1_odo_ff);

   always_comb begin
      if (sum_wide[hhds_pkg::SUM_W] != sum_wide[hhds_pkg::SUM_W-1]) begin
         sum_sat = sum_wide[hhds_pkg::SUM_W] ?
                   {1'b1, {(hhds_pkg::SUM_W-1){1'b0}}} :
                   {1'b0, {(hhds_pkg::SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[hhds_pkg::SUM_W-1:0];
      end
   end

   assign target_scaled = $signed((hhds_pkg::SUM_W + 1)'({target_ff,
                                  {hhds_pkg::FRAC_W{1'b0}}}));
   assign reached = (hhds_pkg::SUM_W + 1)'(sum_sat) >= target_scaled;

   hhds_pkg::status_type                status_in;
   logic signed [hhds_pkg::SPEED_W-1:0] left_in, right_in;

   always_comb begin
      active_in = active_ff;
      ref_in    = ref_ff;
      target_in = target_ff;
      sum_in    = sum_ff;
      status_in = hhds_pkg::ST_IDLE;
      left_in   = '0;
      right_in  = '0;
      if (s1_cmd_ff == hhds_pkg::CMD_START) begin
         target_in = s1_target_ff;
         ref_in    = s1_heading_ff;
         sum_in    = '0;
         active_in = (s1_target_ff != '0);
         status_in = active_in ? hhds_pkg::ST_RUN : hhds_pkg::ST_REACHED;
      end else if (active_ff) begin
         sum_in = sum_sat;
         if (s1_stop_ff.bump) begin
            status_in = hhds_pkg::ST_BUMP;
         end else if (s1_stop_ff.tape) begin
            status_in = hhds_pkg::ST_TAPE;
         end else if (s1_stop_ff.cliff) begin
            status_in = hhds_pkg::ST_CLIFF;
         end else if (reached) begin
            status_in = hhds_pkg::ST_REACHED;
         end else begin
            status_in = hhds_pkg::ST_RUN;
         end
         if (status_in == hhds_pkg::ST_RUN) begin
            left_in  = left_calc;
            right_in = right_calc;
         end else begin
            active_in = 1'b0;
         end
      end
   end

   // remaining distance from the updated state, floor to whole mm
   logic signed [WIDE_W-1:0]              rem_wide;
   logic signed [WIDE_W-1:0]              rem_mm;
   logic signed [hhds_pkg::REMAIN_W-1:0]  remain_in;

   assign rem_wide = $signed(WIDE_W'({target_in, {hhds_pkg::FRAC_W{1'b0}}}))
                     - WIDE_W'(sum_in);
   assign rem_mm   = rem_wide >>> hhds_pkg::FRAC_W;

   always_comb begin
      if (rem_mm > WIDE_W'(hhds_pkg::REMAIN_MAX)) begin
         remain_in = hhds_pkg::REMAIN_W'(hhds_pkg::REMAIN_MAX);
      end else if (rem_mm < WIDE_W'(hhds_pkg::REMAIN_MIN)) begin
         remain_in = hhds_pkg::REMAIN_W'(hhds_pkg::REMAIN_MIN);
      end else begin
         remain_in = rem_mm[hhds_pkg::REMAIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         ref_ff    <= '0;
         target_ff <= '0;
         sum_ff    <= '0;
      end else if (advance) begin
         active_ff <= active_in;
         ref_ff    <= ref_in;
         target_ff <= target_in;
         sum_ff    <= sum_in;
      end
   end

   // response register
   logic                              rsp_valid_ff;
   logic [hhds_pkg::RSP_DATA_W-1:0]   rsp_data_ff;
   logic [hhds_pkg::RSP_DATA_W-1:0]   rsp_data_in;

   assign rsp_data_in = hhds_pkg::RSP_DATA_W'({remain_in, status_in, right_in, left_in});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
